@@ src/mpft_pkg.sv @@
// Package for the masked priority flow match table: sizes, operation and status codes,
// and the word that travels down the cell chain. No dependencies.
package mpft_pkg;

    localparam int ENTRIES   = 64;
    localparam int KEY_WORDS = 2;
    localparam int KEY_W     = 64 * KEY_WORDS;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SEL_W     = 6;
    localparam int SLOT_W    = 6;
    localparam int PRIO_W    = 16;
    localparam int SEL_CMP_W = (IDX_W > SEL_W) ? IDX_W : SEL_W;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_MATCH  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_VALID = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  mask;
        logic [PRIO_W-1:0] prio;
        logic [SEL_W-1:0]  sel;
        logic              done;
        logic [IDX_W-1:0]  slot;
        logic [PRIO_W-1:0] best_prio;
    } t_tok;

endpackage

@@ src/mpft_in_if.sv @@
// Request channel of the flow match table: valid/ready handshake and one request word.
// No dependencies.
interface mpft_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] key_w0;
    logic [63:0] key_w1;
    logic [63:0] mask_w0;
    logic [63:0] mask_w1;
    logic [15:0] prio;
    logic [5:0]  slot_sel;

    modport source (output valid, func, key_w0, key_w1, mask_w0, mask_w1, prio, slot_sel,
                    input ready);
    modport sink   (input valid, func, key_w0, key_w1, mask_w0, mask_w1, prio, slot_sel,
                    output ready);
endinterface

@@ src/mpft_out_if.sv @@
// Response channel of the flow match table: valid/ready handshake and one response word.
// No dependencies.
interface mpft_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        hit;
    logic [5:0]  slot_out;
    logic [15:0] prio_out;

    modport source (output valid, status, hit, slot_out, prio_out, input ready);
    modport sink   (input valid, status, hit, slot_out, prio_out, output ready);
endinterface

@@ src/mpft_cell.sv @@
// One table slot: valid bit, key, mask and priority, plus the chain register that
// hands the request word to the next slot. Depends on mpft_pkg.
module mpft_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic [mpft_pkg::IDX_W-1:0] i_idx,
    input  logic                     i_vld,
    input  mpft_pkg::t_tok           i_tok,
    output logic                     o_vld,
    output mpft_pkg::t_tok           o_tok
);
    import mpft_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_mask;
    logic [PRIO_W-1:0] r_prio;
    logic              wr_en;
    logic              r_vld;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              sel_hit;
    logic              key_hit;

    assign sel_hit = (SEL_CMP_W'(i_tok.sel) == SEL_CMP_W'(i_idx));
    assign key_hit = r_valid && ((i_tok.key & r_mask) == r_key);

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        wr_en   = 1'b0;
        if (i_vld) begin
            case (i_tok.func)
                FN_INSERT: begin
                    if (!i_tok.done && !r_valid) begin
                        wr_en      = 1'b1;
                        n_valid    = 1'b1;
                        n_tok.done = 1'b1;
                        n_tok.slot = i_idx;
                    end
                end
                FN_REMOVE: begin
                    if (sel_hit && r_valid) begin
                        n_valid    = 1'b0;
                        n_tok.done = 1'b1;
                    end
                end
                FN_MATCH: begin
                    if (key_hit && (!i_tok.done || (r_prio > i_tok.best_prio))) begin
                        n_tok.done      = 1'b1;
                        n_tok.slot      = i_idx;
                        n_tok.best_prio = r_prio;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_vld   <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
            if (wr_en) begin
                r_key  <= i_tok.key;
                r_mask <= i_tok.mask;
                r_prio <= i_tok.prio;
            end
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_vld && i_tok.done) |=> r_tok.done)
        else $error("chain word lost its done flag");

    a_one_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_vld && (i_tok.func == FN_INSERT) && i_tok.done) |=> $stable(r_valid))
        else $error("insert claimed a second slot");

    a_remove_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_vld && (i_tok.func == FN_REMOVE) && sel_hit) |=> !r_valid)
        else $error("remove left the slot valid");

endmodule

@@ src/masked_priority_flow_match_table_top.sv @@
// Top level of the masked priority flow match table: the chain of slot cells and the
// response register. Depends on mpft_pkg, mpft_in_if, mpft_out_if and mpft_cell.
//
// Each request word walks the row of ENTRIES slot cells, one cell per cycle while the
// response side is not stalled, and the row is fully pipelined: a new word is taken
// every cycle the response side is not stalled, so the sustained rate is one word per
// cycle. Between acceptance and a valid response the word passes the register of every
// cell in the chain and then the response register. Insert takes the first free slot
// the word passes, remove clears the addressed slot, and match keeps the best hit seen
// so far, replacing it only on strictly higher priority, so the lowest slot wins ties.
// Words never overtake one another, so every request sees the table exactly as earlier
// requests left it. A stall on the response side freezes the whole chain.
module masked_priority_flow_match_table_top (
    input  logic i_clk,
    input  logic i_rst_n,
    mpft_in_if.sink    i_in,
    mpft_out_if.source o_out
);
    import mpft_pkg::*;

    logic              adv;
    logic              c_vld [0:ENTRIES];
    t_tok              c_tok [0:ENTRIES];
    t_tok              last;
    logic              r_out_vld;
    logic [1:0]        r_status;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [PRIO_W-1:0] r_prio;
    logic [1:0]        n_status;
    logic              n_hit;
    logic [SLOT_W-1:0] n_slot;
    logic [PRIO_W-1:0] n_prio;
    logic [2*64-1:0]   key_in;
    logic [2*64-1:0]   mask_in;

    assign adv        = !r_out_vld || o_out.ready;
    assign i_in.ready = adv;

    assign key_in  = {i_in.key_w1, i_in.key_w0};
    assign mask_in = {i_in.mask_w1, i_in.mask_w0};

    always_comb begin
        c_vld[0]           = i_in.valid;
        c_tok[0].func      = i_in.func;
        c_tok[0].key       = key_in[KEY_W-1:0];
        c_tok[0].mask      = mask_in[KEY_W-1:0];
        c_tok[0].prio      = i_in.prio;
        c_tok[0].sel       = i_in.slot_sel;
        c_tok[0].done      = 1'b0;
        c_tok[0].slot      = '0;
        c_tok[0].best_prio = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mpft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_idx   (IDX_W'(g)),
            .i_vld   (c_vld[g]),
            .i_tok   (c_tok[g]),
            .o_vld   (c_vld[g+1]),
            .o_tok   (c_tok[g+1])
        );
    end

    assign last = c_tok[ENTRIES];

    always_comb begin
        n_status = ST_OK;
        n_hit    = 1'b0;
        n_slot   = '0;
        n_prio   = '0;
        case (last.func)
            FN_INSERT: begin
                if (last.done) begin
                    n_slot = SLOT_W'(last.slot);
                end else begin
                    n_status = ST_FULL;
                end
            end
            FN_REMOVE: begin
                n_slot = last.sel;
                if (!last.done) begin
                    n_status = ST_NOT_VALID;
                end
            end
            FN_MATCH: begin
                if (last.done) begin
                    n_hit  = 1'b1;
                    n_slot = SLOT_W'(last.slot);
                    n_prio = last.best_prio;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= c_vld[ENTRIES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= n_status;
            r_hit    <= n_hit;
            r_slot   <= n_slot;
            r_prio   <= n_prio;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.status   = r_status;
    assign o_out.hit      = r_hit;
    assign o_out.slot_out = r_slot;
    assign o_out.prio_out = r_prio;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_hit) |-> (r_prio == '0))
        else $error("response carries a priority without a hit");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_hit) |-> (r_status == ST_OK))
        else $error("hit reported with an error status");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> ($stable(r_slot) && $stable(r_status)))
        else $error("response changed while stalled");

endmodule
